/* src/dqc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqc_pkg
// Shared types, codes and defaults for the double-ended queue core.
// ----------------------------------------------------------------------------
package dqc_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;
    localparam int unsigned WORD_W        = 32;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [1:0]               op_t;
    typedef logic [1:0]               status_t;

    // Operation codes carried by s_op.
    localparam op_t OP_PUSH_FRONT = 2'd0;
    localparam op_t OP_PUSH_BACK  = 2'd1;
    localparam op_t OP_POP_FRONT  = 2'd2;
    localparam op_t OP_POP_BACK   = 2'd3;

    // Status codes carried by m_status.
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_UNDERFLOW = 2'd1;
    localparam status_t ST_OVERFLOW  = 2'd2;

    // Word returned for pushes and for pops on an empty queue.
    localparam word_t NEG_ONE = '1;

endpackage

/* src/double_ended_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Double-ended queue of signed 32-bit words kept in a ring buffer memory.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                    | Direction | Handshake
//  ---------+------------------------------------------+-----------+----------
//  request  | s_op, s_push_value                       | in        | s_valid/s_ready
//  result   | m_pop_value, m_status, m_entries_now     | out       | m_valid/m_ready
//
// A push, and any operation that underflows or overflows, loads its result
// into the output register in the cycle after the item is taken.
// A successful pop reads the entry memory into its registered read port, then
// loads the output register; no new item is taken while that read is in flight.
// Reset (aresetn low, synchronous) empties the queue and the output register;
// the entry memory itself is not cleared, since only written entries are read.
// When m_ready is low with a result waiting, s_ready drops and the block holds.
//
// The front entry sits at head_reg; entry k behind it sits at head_reg + k,
// wrapped modulo DEPTH. DEPTH need not be a power of two: every wrap is a
// single compare and subtract, since the sums never reach twice DEPTH.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
    parameter int unsigned DEPTH = dqc_pkg::DEPTH_DEFAULT,
    localparam int unsigned AW   = $clog2(DEPTH),
    localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  dqc_pkg::op_t          s_op,
    input  dqc_pkg::word_t        s_push_value,

    output logic                  m_valid,
    input  logic                  m_ready,
    output dqc_pkg::word_t        m_pop_value,
    output dqc_pkg::status_t      m_status,
    output logic [CW-1:0]         m_entries_now
);

    localparam int unsigned SW = CW + 1;

    // Queue bookkeeping.
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;

    // Set while a pop's memory read is in flight.
    logic pend_reg, pend_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    dqc_pkg::word_t    value_reg, value_next;
    dqc_pkg::status_t  status_reg, status_next;
    logic [CW-1:0]     entries_reg, entries_next;

    // Entry memory.
    dqc_pkg::word_t mem [DEPTH];
    dqc_pkg::word_t rd_data_reg;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;

    logic             accept;
    logic             empty;
    logic             full;
    logic             pop_ok;
    dqc_pkg::status_t step_status;
    logic [AW-1:0]    front_dec;
    logic [AW-1:0]    front_inc;
    logic [SW-1:0]    back_sum;
    logic [SW-1:0]    last_sum;
    logic [AW-1:0]    back_free;
    logic [AW-1:0]    back_last;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !pend_reg && out_free;
    assign accept   = s_valid && s_ready;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));

    // Neighbor indices of the head, wrapped.
    assign front_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign front_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);

    // Slot behind the last entry and the last entry itself.
    assign back_sum  = SW'(head_reg) + SW'(count_reg);
    assign last_sum  = back_sum - SW'(1);
    assign back_free = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH))
                                                : AW'(back_sum);
    assign back_last = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH))
                                                : AW'(last_sum);

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        wr_en       = 1'b0;
        wr_addr     = back_free;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        pop_ok      = 1'b0;
        step_status = dqc_pkg::ST_OK;
        unique case (s_op)
            dqc_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    step_status = dqc_pkg::ST_OVERFLOW;
                end else begin
                    wr_en      = accept;
                    wr_addr    = front_dec;
                    head_next  = front_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            dqc_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    step_status = dqc_pkg::ST_OVERFLOW;
                end else begin
                    wr_en      = accept;
                    wr_addr    = back_free;
                    count_next = count_reg + CW'(1);
                end
            end
            dqc_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    step_status = dqc_pkg::ST_UNDERFLOW;
                end else begin
                    pop_ok     = 1'b1;
                    rd_en      = accept;
                    rd_addr    = head_reg;
                    head_next  = front_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            dqc_pkg::OP_POP_BACK: begin
                if (empty) begin
                    step_status = dqc_pkg::ST_UNDERFLOW;
                end else begin
                    pop_ok     = 1'b1;
                    rd_en      = accept;
                    rd_addr    = back_last;
                    count_next = count_reg - CW'(1);
                end
            end
            default: begin
                step_status = dqc_pkg::ST_OK;
            end
        endcase
    end

    // Output register: immediate results load on accept, pop data loads once
    // the read returns and the register is free.
    always_comb begin
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        value_next   = value_reg;
        status_next  = status_reg;
        entries_next = entries_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept && !pop_ok) begin
            m_valid_next = 1'b1;
            value_next   = dqc_pkg::NEG_ONE;
            status_next  = step_status;
            entries_next = count_next;
        end else if (accept && pop_ok) begin
            pend_next = 1'b1;
        end else if (pend_reg && out_free) begin
            pend_next    = 1'b0;
            m_valid_next = 1'b1;
            value_next   = rd_data_reg;
            status_next  = dqc_pkg::ST_OK;
            entries_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg   <= value_next;
        status_reg  <= status_next;
        entries_reg <= entries_next;
    end

    // Entry memory with a registered read port. A push writes at its accept
    // edge; the earliest pop reads at the next edge, after the write has
    // landed, so no bypass is needed.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_push_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pop_value   = value_reg;
    assign m_status      = status_reg;
    assign m_entries_now = entries_reg;

`ifndef ASSERT_OFF
    // The entry count never exceeds the ring size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above DEPTH");

    // No new item is taken while a pop read is in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !s_ready)
        else $error("item accepted during pending pop");

    // A pop on a non-empty queue always starts a memory read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !empty && (s_op == dqc_pkg::OP_POP_FRONT ||
                              s_op == dqc_pkg::OP_POP_BACK)) |=> pend_reg)
        else $error("pop did not start a read");
`endif

endmodule

/* test/tb_double_ended_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_core
// Self-checking testbench for the double-ended queue core.
// ----------------------------------------------------------------------------
// A short table of directed items covers pops on an empty deque, popping the
// back of a single entry, the word extremes, front and back wrap of the ring,
// a fill to capacity and pushes on a full deque. About 850 random items follow.
// Their mix drifts between push-heavy, pop-heavy and balanced spells, so the
// deque keeps crossing full and empty. Every accepted item is run through a
// ring-buffer predictor kept in this file. Every result the block hands over
// is compared field by field with the oldest owed result.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_core;

    localparam int unsigned DEPTH        = dqc_pkg::DEPTH_DEFAULT;
    localparam int unsigned CNT_W        = $clog2(DEPTH + 1);
    localparam int          RANDOM_ITEMS = 850;
    localparam int          LIMIT_CYCLES = 200000;
    // Idle cycles given after the last result so the block can settle.
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD     = 64;

    typedef struct {
        dqc_pkg::word_t    pop_value;
        dqc_pkg::status_t  status;
        logic [CNT_W-1:0]  entries;
    } deque_result_t;

    typedef struct {
        dqc_pkg::op_t   op;
        dqc_pkg::word_t value;
        bit             typed_in;
        deque_result_t  want;
    } stim_row_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    dqc_pkg::op_t      s_op;
    dqc_pkg::word_t    s_push_value;
    logic              m_valid;
    logic              m_ready = 1'b0;
    dqc_pkg::word_t    m_pop_value;
    dqc_pkg::status_t  m_status;
    logic [CNT_W-1:0]  m_entries_now;

    double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_push_value  (s_push_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pop_value   (m_pop_value),
        .m_status      (m_status),
        .m_entries_now (m_entries_now)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Ring-buffer predictor. It keeps its own copy of the entries, the index
    // of the front entry and the fill level. The entry k places behind the
    // front sits at (ring_head + k) mod DEPTH.
    // ------------------------------------------------------------------------
    dqc_pkg::word_t ring_words [DEPTH];
    int    ring_head = 0;
    int    ring_fill = 0;

    function automatic deque_result_t predict_deque_step(dqc_pkg::op_t op,
                                                         dqc_pkg::word_t value);
        deque_result_t res;
        res.pop_value = dqc_pkg::NEG_ONE;
        res.status    = dqc_pkg::ST_OK;
        case (op)
            dqc_pkg::OP_PUSH_FRONT: begin
                if (ring_fill >= DEPTH) begin
                    res.status = dqc_pkg::ST_OVERFLOW;
                end else begin
                    ring_head = (ring_head + DEPTH - 1) % DEPTH;
                    ring_words[ring_head] = value;
                    ring_fill++;
                end
            end
            dqc_pkg::OP_PUSH_BACK: begin
                if (ring_fill >= DEPTH) begin
                    res.status = dqc_pkg::ST_OVERFLOW;
                end else begin
                    ring_words[(ring_head + ring_fill) % DEPTH] = value;
                    ring_fill++;
                end
            end
            dqc_pkg::OP_POP_FRONT: begin
                if (ring_fill == 0) begin
                    res.status = dqc_pkg::ST_UNDERFLOW;
                end else begin
                    res.pop_value = ring_words[ring_head];
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_fill--;
                end
            end
            default: begin
                // Pop back. Taking the last entry leaves the deque empty.
                if (ring_fill == 0) begin
                    res.status = dqc_pkg::ST_UNDERFLOW;
                end else begin
                    res.pop_value = ring_words[(ring_head + ring_fill - 1) % DEPTH];
                    ring_fill--;
                end
            end
        endcase
        res.entries = CNT_W'(ring_fill);
        return res;
    endfunction

    // Results still owed by the block, oldest first.
    deque_result_t owed_results[$];

    int error_count     = 0;
    int results_checked = 0;
    int cycle_count     = 0;
    int items_sent      = 0;
    int directed_count  = 0;
    int push_count      = 0;
    int pop_count       = 0;
    int underflow_count = 0;
    int overflow_count  = 0;
    int peak_fill       = 0;
    int long_holds      = 0;

    // ------------------------------------------------------------------------
    // Sender. Items go out in bursts of random length. Between bursts the
    // valid line drops for a few cycles. Now and then a long burst gives a
    // stretch with no idling at all. Valid is raised at a rising edge and held
    // with its payload until the edge at which ready is seen high.
    // ------------------------------------------------------------------------
    int burst_left = 0;

    task automatic offer_item(dqc_pkg::op_t op, dqc_pkg::word_t value, bit typed_in,
                              deque_result_t want);
        deque_result_t predicted;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_op         <= op;
        s_push_value <= value;
        do @(posedge aclk); while (!s_ready);

        // The item was taken at this edge, so the predictor steps now.
        predicted = predict_deque_step(op, value);
        owed_results.push_back(typed_in ? want : predicted);
        items_sent++;
        if (predicted.status == dqc_pkg::ST_UNDERFLOW) begin
            underflow_count++;
        end else if (predicted.status == dqc_pkg::ST_OVERFLOW) begin
            overflow_count++;
        end else if (op == dqc_pkg::OP_PUSH_FRONT || op == dqc_pkg::OP_PUSH_BACK) begin
            push_count++;
        end else begin
            pop_count++;
        end
        if (ring_fill > peak_fill) peak_fill = ring_fill;
    endtask

    // The sender stops and waits until every owed result has arrived, then
    // gives a popping read time to finish.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Words near the extremes turn up more often than $urandom alone gives.
    function automatic dqc_pkg::word_t pick_word();
        case ($urandom_range(0, 11))
            0:       return dqc_pkg::word_t'(32'h0000_0000);
            1:       return dqc_pkg::NEG_ONE;
            2:       return dqc_pkg::word_t'(32'h7FFF_FFFF);
            3:       return dqc_pkg::word_t'(32'h8000_0000);
            default: return dqc_pkg::word_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver. At the start of each style window it picks a readiness style:
    // always ready, coin toss, mostly stalled or mostly ready. Twice during the
    // run ready is held low for a long stretch. The output register then stays
    // full and the block must hold off the sender, which keeps offering items.
    // ------------------------------------------------------------------------
    int ready_style   = 0;
    int style_left    = 0;
    int hold_left     = 0;
    int next_hold_at  = 150;

    always @(posedge aclk) begin
        if (style_left == 0) begin
            ready_style = $urandom_range(0, 3);
            style_left  = 32;
        end
        style_left--;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (long_holds < 2 && results_checked >= next_hold_at) begin
            hold_left    = LONG_HOLD - 1;
            long_holds++;
            next_hold_at = 520;
            m_ready <= 1'b0;
        end else begin
            case (ready_style)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 1) == 1);
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result check. Both handshake lines are sampled at the rising edge, so
    // the values seen are the ones that were stable before it. A result with
    // nothing owed is an error, and so is any field that differs.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        deque_result_t owed;
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                $display("%0t: result with none owed: pop_value %0d status %0d %s %0d",
                         $time, m_pop_value, m_status, "entries", m_entries_now);
                error_count++;
            end else begin
                owed = owed_results.pop_front();
                results_checked++;
                if (m_pop_value !== owed.pop_value) begin
                    $display("%0t: pop_value expected %0d got %0d",
                             $time, owed.pop_value, m_pop_value);
                    error_count++;
                end
                if (m_status !== owed.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, owed.status, m_status);
                    error_count++;
                end
                if (m_entries_now !== owed.entries) begin
                    $display("%0t: entries_now expected %0d got %0d",
                             $time, owed.entries, m_entries_now);
                    error_count++;
                end
            end
        end
    end

    // The run is bounded by a cycle count far above what a correct block needs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timed out with %0d results still owed", $time, owed_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    stim_row_t directed_rows[$];

    task automatic add_row(dqc_pkg::op_t op, dqc_pkg::word_t value, bit typed_in,
                           dqc_pkg::word_t pop_value, dqc_pkg::status_t status,
                           int entries);
        stim_row_t row;
        row.op             = op;
        row.value          = value;
        row.typed_in       = typed_in;
        row.want.pop_value = pop_value;
        row.want.status    = status;
        row.want.entries   = CNT_W'(entries);
        directed_rows.push_back(row);
    endtask

    initial begin
        int             mix_mode;
        int             roll;
        dqc_pkg::op_t   op;
        dqc_pkg::word_t word;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = dqc_pkg::OP_PUSH_FRONT;
        s_push_value = '0;

        // Directed items. Rows with a typed result hold values that can be
        // read straight off the behavior. The fill rows are left to the
        // predictor.
        add_row(dqc_pkg::OP_POP_FRONT, dqc_pkg::word_t'($urandom), 1'b1,
                dqc_pkg::NEG_ONE, dqc_pkg::ST_UNDERFLOW, 0);
        add_row(dqc_pkg::OP_POP_BACK, dqc_pkg::word_t'($urandom), 1'b1,
                dqc_pkg::NEG_ONE, dqc_pkg::ST_UNDERFLOW, 0);
        add_row(dqc_pkg::OP_PUSH_BACK, dqc_pkg::word_t'(32'h7FFF_FFFF), 1'b1,
                dqc_pkg::NEG_ONE, dqc_pkg::ST_OK, 1);
        // Popping the back of a single entry must empty the deque.
        add_row(dqc_pkg::OP_POP_BACK, dqc_pkg::word_t'($urandom), 1'b1,
                dqc_pkg::word_t'(32'h7FFF_FFFF), dqc_pkg::ST_OK, 0);
        add_row(dqc_pkg::OP_POP_FRONT, dqc_pkg::word_t'($urandom), 1'b1,
                dqc_pkg::NEG_ONE, dqc_pkg::ST_UNDERFLOW, 0);
        // A push at the front of an empty deque wraps the head below zero.
        add_row(dqc_pkg::OP_PUSH_FRONT, dqc_pkg::word_t'(32'h8000_0000), 1'b1,
                dqc_pkg::NEG_ONE, dqc_pkg::ST_OK, 1);
        add_row(dqc_pkg::OP_POP_FRONT, dqc_pkg::word_t'($urandom), 1'b1,
                dqc_pkg::word_t'(32'h8000_0000), dqc_pkg::ST_OK, 0);
        for (int k = 0; k < DEPTH; k++) begin
            add_row(k[0] ? dqc_pkg::OP_PUSH_BACK : dqc_pkg::OP_PUSH_FRONT,
                    dqc_pkg::word_t'(32'h0F0F_0F0F * k) ^
                        (k[1] ? 32'hAAAA_AAAA : 32'h5555_5555),
                    1'b0, dqc_pkg::NEG_ONE, dqc_pkg::ST_OK, 0);
        end
        // Both kinds of push on a full deque are dropped.
        add_row(dqc_pkg::OP_PUSH_FRONT, pick_word(), 1'b1,
                dqc_pkg::NEG_ONE, dqc_pkg::ST_OVERFLOW, DEPTH);
        add_row(dqc_pkg::OP_PUSH_BACK, pick_word(), 1'b1,
                dqc_pkg::NEG_ONE, dqc_pkg::ST_OVERFLOW, DEPTH);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            offer_item(directed_rows[i].op, directed_rows[i].value,
                       directed_rows[i].typed_in, directed_rows[i].want);
        end
        directed_count = items_sent;
        wait_for_drain();

        // Random items. Every 40 items the mix changes: push-heavy spells fill
        // the deque to overflow, pop-heavy spells drain it to underflow, and
        // balanced spells churn it in the middle with wrapping indices.
        mix_mode = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) mix_mode = $urandom_range(0, 2);
            if (i == RANDOM_ITEMS / 2) wait_for_drain();
            roll = $urandom_range(0, 99);
            case (mix_mode)
                0:       op = (roll < 75) ? dqc_pkg::OP_PUSH_FRONT : dqc_pkg::OP_POP_FRONT;
                1:       op = (roll < 25) ? dqc_pkg::OP_PUSH_FRONT : dqc_pkg::OP_POP_FRONT;
                default: op = (roll < 50) ? dqc_pkg::OP_PUSH_FRONT : dqc_pkg::OP_POP_FRONT;
            endcase
            // The low bit picks the end of the deque.
            op[0] = 1'($urandom_range(0, 1));
            word  = pick_word();
            offer_item(op, word, 1'b0, '{default: '0});
        end

        wait_for_drain();

        if (owed_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, owed_results.size());
            error_count++;
        end
        $display("Sent %0d items (%0d directed): %0d pushes, %0d pops,",
                 items_sent, directed_count, push_count, pop_count);
        $display("  %0d underflows, %0d overflows.", underflow_count, overflow_count);
        $display("Checked %0d results; peak fill %0d of %0d; %0d long output stalls.",
                 results_checked, peak_fill, DEPTH, long_holds);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* double_ended_queue_core.f */
src/dqc_pkg.sv
src/double_ended_queue_core.sv
test/tb_double_ended_queue_core.sv
